[design/tcdp_pkg.sv]
package tcdp_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CMD_IDX_W  = 3;
    localparam int unsigned WORD_W     = 32;
    localparam int unsigned NUM_PARAMS = 3;

    // register map of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_COMMAND_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CMD_WORD_0    = 3'd1;

    localparam logic [7:0] CHAR_HASH  = 8'h23;
    localparam logic [7:0] CHAR_STAR  = 8'h2A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;

    localparam logic [2:0] CMD_LEN = 3'd4;
    localparam logic [1:0] FIELD_PAST = 2'd3;

    typedef enum logic [1:0] {
        PH_BEFORE = 2'd0,
        PH_SIGN   = 2'd1,
        PH_DIGITS = 2'd2,
        PH_DONE   = 2'd3
    } t_phase;

    // command code collected by the parser, handed to the matcher
    typedef struct packed {
        logic              full;
        logic [WORD_W-1:0] code;
    } t_cmd_info;

    typedef struct packed {
        logic                 hit;
        logic [CMD_IDX_W-1:0] index;
    } t_match;

endpackage

[design/tcdp_cfg.sv]
module tcdp_cfg #(
    parameter int MAX_COMMANDS = 6
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    input  logic [tcdp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [tcdp_pkg::WORD_W-1:0]        i_cfg_data,
    output logic [tcdp_pkg::CMD_IDX_W-1:0]     o_limit,
    output logic [tcdp_pkg::WORD_W-1:0]        o_words [MAX_COMMANDS]
);

    logic [tcdp_pkg::CMD_IDX_W-1:0] r_count;
    logic [tcdp_pkg::WORD_W-1:0]    r_words [MAX_COMMANDS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            for (int i = 0; i < MAX_COMMANDS; i++) begin
                r_words[i] <= '0;
            end
        end else if (i_cfg_valid) begin
            if (i_cfg_index == tcdp_pkg::REG_COMMAND_COUNT) begin
                r_count <= i_cfg_data[tcdp_pkg::CMD_IDX_W-1:0];
            end
            // words past MAX_COMMANDS are never compared, so writes to them drop
            for (int i = 0; i < MAX_COMMANDS; i++) begin
                if (i_cfg_index == tcdp_pkg::REG_CMD_WORD_0 + tcdp_pkg::CFG_IDX_W'(i)) begin
                    r_words[i] <= i_cfg_data;
                end
            end
        end
    end

    assign o_limit = (r_count > tcdp_pkg::CMD_IDX_W'(MAX_COMMANDS))
                   ? tcdp_pkg::CMD_IDX_W'(MAX_COMMANDS) : r_count;
    assign o_words = r_words;

endmodule

[design/tcdp_match.sv]
module tcdp_match #(
    parameter int MAX_COMMANDS = 6
) (
    input  tcdp_pkg::t_cmd_info             i_cmd,
    input  logic [tcdp_pkg::CMD_IDX_W-1:0]  i_limit,
    input  logic [tcdp_pkg::WORD_W-1:0]     i_words [MAX_COMMANDS],
    output tcdp_pkg::t_match                o_match
);

    always_comb begin
        o_match = '0;
        // walk downward so the lowest matching index wins
        for (int i = MAX_COMMANDS - 1; i >= 0; i--) begin
            if (i_cmd.full && (tcdp_pkg::CMD_IDX_W'(i) < i_limit)
                    && (i_words[i] == i_cmd.code)) begin
                o_match.hit   = 1'b1;
                o_match.index = tcdp_pkg::CMD_IDX_W'(i);
            end
        end
    end

endmodule

[design/tcdp_parse.sv]
module tcdp_parse (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_step,
    input  logic [7:0]                   i_byte,
    output tcdp_pkg::t_cmd_info          o_cmd,
    output logic [tcdp_pkg::WORD_W-1:0]  o_values [tcdp_pkg::NUM_PARAMS]
);

    logic [2:0]                  r_char_pos, n_char_pos;
    logic [tcdp_pkg::WORD_W-1:0] r_cmd_shift, n_cmd_shift;
    logic [1:0]                  r_field, n_field;
    tcdp_pkg::t_phase            r_phase, n_phase;
    logic                        r_neg, n_neg;
    logic [tcdp_pkg::WORD_W-1:0] r_val [tcdp_pkg::NUM_PARAMS];
    logic [tcdp_pkg::WORD_W-1:0] n_val [tcdp_pkg::NUM_PARAMS];

    logic                        is_digit;
    logic                        is_ws;
    logic [tcdp_pkg::WORD_W-1:0] digit;
    logic [tcdp_pkg::WORD_W-1:0] acc;
    logic [tcdp_pkg::WORD_W-1:0] acc_x10;
    logic [tcdp_pkg::WORD_W-1:0] acc_next;

    assign is_digit = (i_byte >= tcdp_pkg::CHAR_ZERO) && (i_byte <= tcdp_pkg::CHAR_NINE);
    assign is_ws    = (i_byte >= tcdp_pkg::CHAR_TAB) && (i_byte <= tcdp_pkg::CHAR_CR);
    assign digit    = {{(tcdp_pkg::WORD_W-4){1'b0}}, i_byte[3:0]};

    always_comb begin
        unique case (r_field)
            2'd0:    acc = r_val[0];
            2'd1:    acc = r_val[1];
            2'd2:    acc = r_val[2];
            default: acc = '0;
        endcase
    end

    assign acc_x10  = (acc << 3) + (acc << 1);
    assign acc_next = r_neg ? (acc_x10 - digit) : (acc_x10 + digit);

    always_comb begin
        n_char_pos  = r_char_pos;
        n_cmd_shift = r_cmd_shift;
        n_field     = r_field;
        n_phase     = r_phase;
        n_neg       = r_neg;
        n_val       = r_val;

        if (i_step) begin
            priority if (i_byte == tcdp_pkg::CHAR_HASH) begin
                n_char_pos  = '0;
                n_cmd_shift = '0;
                n_field     = '0;
                n_phase     = tcdp_pkg::PH_BEFORE;
                n_neg       = 1'b0;
                for (int i = 0; i < tcdp_pkg::NUM_PARAMS; i++) begin
                    n_val[i] = '0;
                end
            end else if (r_char_pos < tcdp_pkg::CMD_LEN) begin
                n_cmd_shift = {r_cmd_shift[tcdp_pkg::WORD_W-9:0], i_byte};
                n_char_pos  = r_char_pos + 3'd1;
            end else if (i_byte == tcdp_pkg::CHAR_STAR) begin
                if (r_field != tcdp_pkg::FIELD_PAST) begin
                    n_field = r_field + 2'd1;
                end
                n_phase = tcdp_pkg::PH_BEFORE;
                n_neg   = 1'b0;
            end else if (r_field != tcdp_pkg::FIELD_PAST && i_byte != tcdp_pkg::CHAR_SPACE) begin
                unique case (r_phase)
                    tcdp_pkg::PH_BEFORE: begin
                        priority if (is_ws) begin
                            n_phase = r_phase;
                        end else if (i_byte == tcdp_pkg::CHAR_PLUS
                                  || i_byte == tcdp_pkg::CHAR_MINUS) begin
                            n_neg   = (i_byte == tcdp_pkg::CHAR_MINUS);
                            n_phase = tcdp_pkg::PH_SIGN;
                        end else if (is_digit) begin
                            n_phase = tcdp_pkg::PH_DIGITS;
                        end else begin
                            n_phase = tcdp_pkg::PH_DONE;
                        end
                    end
                    tcdp_pkg::PH_SIGN, tcdp_pkg::PH_DIGITS: begin
                        n_phase = is_digit ? tcdp_pkg::PH_DIGITS : tcdp_pkg::PH_DONE;
                    end
                    default: begin
                        n_phase = r_phase;
                    end
                endcase
                // a digit only accumulates while the number is still open
                if (is_digit && r_phase != tcdp_pkg::PH_DONE) begin
                    for (int i = 0; i < tcdp_pkg::NUM_PARAMS; i++) begin
                        if (r_field == 2'(i)) begin
                            n_val[i] = acc_next;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_char_pos  <= '0;
            r_cmd_shift <= '0;
            r_field     <= '0;
            r_phase     <= tcdp_pkg::PH_BEFORE;
            r_neg       <= 1'b0;
            for (int i = 0; i < tcdp_pkg::NUM_PARAMS; i++) begin
                r_val[i] <= '0;
            end
        end else begin
            r_char_pos  <= n_char_pos;
            r_cmd_shift <= n_cmd_shift;
            r_field     <= n_field;
            r_phase     <= n_phase;
            r_neg       <= n_neg;
            r_val       <= n_val;
        end
    end

    assign o_cmd.full = (r_char_pos >= tcdp_pkg::CMD_LEN);
    assign o_cmd.code = r_cmd_shift;
    assign o_values   = r_val;

endmodule

[design/text_command_dispatch_parser_top.sv]
// Text command parser. Bytes of a command stream enter on the input channel
// (i_in_valid / o_in_stall / i_in_byte); each '#' closes a message and yields one
// result on the output channel (o_out_valid / i_out_stall) carrying the match
// flag, the index of the first matching command word and three parameters.
// Other bytes produce no result.
// The configuration channel (i_cfg_valid / o_cfg_ready / i_cfg_index /
// i_cfg_data) is always ready: index 0 is the command count, 1..6 the command
// words. Write it only while no message is in flight.
// Throughput: one byte per cycle while no '#' is held back by a stalled output.
// A byte is captured in the input register and parsed from there; a '#' writes
// its result into the output register when it is parsed. The per-byte path is
// one multiply-by-ten with add or subtract and the six word compares.
// While the receiver stalls, non-'#' bytes keep flowing; a '#' that finds the
// output register still held waits in the input register with o_in_stall high
// until the result ahead of it is taken. Reset clears the message state, the
// command count and words.
module text_command_dispatch_parser_top #(
    parameter int MAX_COMMANDS = 6
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [7:0]                          i_in_byte,

    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_matched,
    output logic [tcdp_pkg::CMD_IDX_W-1:0]      o_command_index,
    output logic signed [tcdp_pkg::WORD_W-1:0]  o_param_a,
    output logic signed [tcdp_pkg::WORD_W-1:0]  o_param_b,
    output logic signed [tcdp_pkg::WORD_W-1:0]  o_param_c,

    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [tcdp_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tcdp_pkg::WORD_W-1:0]         i_cfg_data
);

    logic                           r_in_valid;
    logic [7:0]                     r_in_byte;
    logic                           r_out_valid;
    logic                           r_matched;
    logic [tcdp_pkg::CMD_IDX_W-1:0] r_index;
    logic [tcdp_pkg::WORD_W-1:0]    r_param [tcdp_pkg::NUM_PARAMS];

    logic                           in_take;
    logic                           is_hash;
    logic                           step;
    logic                           emit;

    logic [tcdp_pkg::CMD_IDX_W-1:0] limit;
    logic [tcdp_pkg::WORD_W-1:0]    words [MAX_COMMANDS];
    tcdp_pkg::t_cmd_info            cmd;
    tcdp_pkg::t_match               match;
    logic [tcdp_pkg::WORD_W-1:0]    values [tcdp_pkg::NUM_PARAMS];

    assign is_hash    = (r_in_byte == tcdp_pkg::CHAR_HASH);
    assign step       = r_in_valid && !(is_hash && r_out_valid && i_out_stall);
    assign emit       = step && is_hash;
    assign o_in_stall = r_in_valid && !step;
    assign in_take    = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= in_take || (r_in_valid && !step);
            r_out_valid <= emit || (r_out_valid && i_out_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_in_byte;
        end
        if (emit) begin
            r_matched <= match.hit;
            r_index   <= match.index;
            r_param   <= values;
        end
    end

    tcdp_cfg #(
        .MAX_COMMANDS (MAX_COMMANDS)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_limit     (limit),
        .o_words     (words)
    );

    tcdp_parse u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_byte   (r_in_byte),
        .o_cmd    (cmd),
        .o_values (values)
    );

    tcdp_match #(
        .MAX_COMMANDS (MAX_COMMANDS)
    ) u_match (
        .i_cmd   (cmd),
        .i_limit (limit),
        .i_words (words),
        .o_match (match)
    );

    assign o_out_valid     = r_out_valid;
    assign o_matched       = r_matched;
    assign o_command_index = r_index;
    assign o_param_a       = $signed(r_param[0]);
    assign o_param_b       = $signed(r_param[1]);
    assign o_param_c       = $signed(r_param[2]);

endmodule
